>>> hdl/input_event_record_generator_core_defines.svh
// Assertion macros used by the RTL core.
`ifndef INPUT_EVENT_RECORD_GENERATOR_CORE_DEFINES_SVH
`define INPUT_EVENT_RECORD_GENERATOR_CORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define IERG_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define IERG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/ierg_pkg.sv
package ierg_pkg;

    localparam int NUM_SLOTS = 7;
    localparam int NUM_BTNS  = 3;

    // event types
    localparam logic [1:0] EVT_SYNC = 2'd0;
    localparam logic [1:0] EVT_KEY  = 2'd1;
    localparam logic [1:0] EVT_REL  = 2'd2;
    localparam logic [1:0] EVT_ABS  = 2'd3;

    // device types
    localparam logic [1:0] DEV_KEYBOARD = 2'd0;
    localparam logic [1:0] DEV_MOUSE    = 2'd1;
    localparam logic [1:0] DEV_TABLET   = 2'd2;

    // report kinds
    localparam logic FUNC_KEY     = 1'b0;
    localparam logic FUNC_POINTER = 1'b1;

    localparam logic [15:0] AXIS_X     = 16'h0000;
    localparam logic [15:0] AXIS_Y     = 16'h0001;
    localparam logic [15:0] AXIS_WHEEL = 16'h0008;

    localparam logic [15:0] BTN_CODES [NUM_BTNS] = '{16'h0110, 16'h0111, 16'h0112};

    // record slots, in output order
    localparam logic [2:0] SLOT_FIRST  = 3'd0;  // key / X / rejected
    localparam logic [2:0] SLOT_SECOND = 3'd1;  // key sync / Y
    localparam logic [2:0] SLOT_WHEEL  = 3'd2;
    localparam logic [2:0] SLOT_LEFT   = 3'd3;
    localparam logic [2:0] SLOT_RIGHT  = 3'd4;
    localparam logic [2:0] SLOT_MIDDLE = 3'd5;
    localparam logic [2:0] SLOT_SYNC   = 3'd6;

    typedef struct packed {
        logic        func;
        logic        key_down;
        logic [15:0] key_id;
        logic [31:0] delta_x;
        logic [31:0] delta_y;
        logic [31:0] wheel_delta;
        logic [2:0]  button_bits;
    } report_t;

    typedef struct packed {
        logic [1:0]  event_type;
        logic [15:0] event_code;
        logic [31:0] event_value;
        logic        rejected;
        logic        last;
    } rec_t;

    typedef struct packed {
        logic [NUM_SLOTS-1:0] present;  // slots this report produces
        logic [NUM_SLOTS-1:0] sel;      // one-hot slot sent now
        logic                 accepted; // report matches the device type
    } slot_ctrl_t;

endpackage

>>> hdl/ierg_rec_gen.sv
module ierg_rec_gen
    import ierg_pkg::*;
(
    input  report_t              report,
    input  logic [1:0]           device_type,
    input  logic [2:0]           prior_buttons,
    input  logic [NUM_SLOTS-1:0] done,
    output rec_t                 rec,
    output slot_ctrl_t           ctrl
);

    logic                 is_key;
    logic                 is_ptr;
    logic [1:0]           axis_type;
    logic [2:0]           btn_change;
    logic [NUM_SLOTS-1:0] present;
    logic [NUM_SLOTS-1:0] sel;
    logic                 accepted;
    logic [NUM_SLOTS-1:0] pend;
    logic [2:0]           slot;
    logic                 found;

    always_comb begin
        is_key     = (report.func == FUNC_KEY) && (device_type == DEV_KEYBOARD);
        is_ptr     = (report.func == FUNC_POINTER) &&
                     ((device_type == DEV_MOUSE) || (device_type == DEV_TABLET));
        axis_type  = (device_type == DEV_MOUSE) ? EVT_REL : EVT_ABS;
        btn_change = report.button_bits ^ prior_buttons;

        accepted = is_key || is_ptr;
        if (is_key) begin
            present = 7'b0000011;
        end else if (is_ptr) begin
            present = {1'b1, btn_change, (report.wheel_delta != 32'd0), 2'b11};
        end else begin
            present = 7'b0000001;
        end
    end

    // lowest outstanding slot goes next
    always_comb begin
        pend  = present & ~done;
        slot  = SLOT_FIRST;
        found = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (pend[i] && !found) begin
                slot  = 3'(i);
                found = 1'b1;
            end
        end
        sel = found ? (NUM_SLOTS'(1) << slot) : '0;
    end

    assign ctrl = {present, sel, accepted};

    always_comb begin
        rec.event_type  = EVT_SYNC;
        rec.event_code  = '0;
        rec.event_value = '0;
        rec.rejected    = 1'b0;
        rec.last        = ((pend & ~sel) == '0);
        unique case (slot)
            SLOT_FIRST: begin
                if (is_key) begin
                    rec.event_type  = EVT_KEY;
                    rec.event_code  = report.key_id;
                    rec.event_value = {31'd0, report.key_down};
                end else if (is_ptr) begin
                    rec.event_type  = axis_type;
                    rec.event_code  = AXIS_X;
                    rec.event_value = report.delta_x;
                end else begin
                    rec.rejected    = 1'b1;
                end
            end
            SLOT_SECOND: begin
                if (is_ptr) begin
                    rec.event_type  = axis_type;
                    rec.event_code  = AXIS_Y;
                    rec.event_value = report.delta_y;
                end
            end
            SLOT_WHEEL: begin
                rec.event_type  = EVT_REL;
                rec.event_code  = AXIS_WHEEL;
                rec.event_value = report.wheel_delta;
            end
            SLOT_LEFT: begin
                rec.event_type  = EVT_KEY;
                rec.event_code  = BTN_CODES[0];
                rec.event_value = {31'd0, report.button_bits[0]};
            end
            SLOT_RIGHT: begin
                rec.event_type  = EVT_KEY;
                rec.event_code  = BTN_CODES[1];
                rec.event_value = {31'd0, report.button_bits[1]};
            end
            SLOT_MIDDLE: begin
                rec.event_type  = EVT_KEY;
                rec.event_code  = BTN_CODES[2];
                rec.event_value = {31'd0, report.button_bits[2]};
            end
            default: begin
                // trailing sync record, already the default values
                rec.event_type  = EVT_SYNC;
            end
        endcase
    end

endmodule

>>> hdl/input_event_record_generator_core.sv
// Input event record generator.
// Slave channel (s_*): one key or pointer report per transfer; s_tuser carries
// the report kind. Master channel (m_*): one event record per transfer, with
// m_tlast high on the final record of each report's run.
// cfg_we/cfg_wdata set the device type (keyboard, mouse, tablet); write it
// only while no report is in flight.
// Flow: a report transfer is captured in the input register, and its records are
// loaded from there into the output register. Records then leave one per cycle
// while the receiver takes them; a report yields 1 (rejected), 2 (key) or 3 to 7
// (pointer) records, all passing through the single output register. The next report is
// taken in the same cycle as the previous report's last record is loaded.
// Reset clears the device type to keyboard, the remembered button state and all
// valid flags. When the receiver stalls, the current record holds on m_* and the
// held report waits in the input register; s_tready drops until the run moves on.
`include "input_event_record_generator_core_defines.svh"

module input_event_record_generator_core
    import ierg_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [0] key_down, [16:1] key_id, [48:17] delta_x, [80:49] delta_y,
    // [112:81] wheel_delta, [115:113] button_bits, [119:116] zero
    input  logic [119:0] s_tdata,
    // [0] func
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [15:0] event_code, [47:16] event_value
    output logic [47:0]  m_tdata,
    // [1:0] event_type, [2] rejected
    output logic [2:0]   m_tuser,
    output logic         m_tlast
);

    logic [1:0]           device_type_reg;
    logic [2:0]           prior_reg;
    logic                 in_valid_reg;
    report_t              in_reg;
    logic [NUM_SLOTS-1:0] done_reg;
    logic [NUM_SLOTS-1:0] done_next;
    logic                 m_valid_reg;
    rec_t                 m_reg;
    rec_t                 rec;
    slot_ctrl_t           ctrl;
    logic                 load;
    logic                 run_end;

    ierg_rec_gen u_rec_gen (
        .report        (in_reg),
        .device_type   (device_type_reg),
        .prior_buttons (prior_reg),
        .done          (done_reg),
        .rec           (rec),
        .ctrl          (ctrl)
    );

    assign load     = in_valid_reg && (!m_valid_reg || m_tready);
    assign run_end  = load && rec.last;
    assign s_tready = !in_valid_reg || run_end;

    always_comb begin
        done_next = done_reg;
        if (load) begin
            done_next = rec.last ? '0 : (done_reg | ctrl.sel);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            device_type_reg <= DEV_KEYBOARD;
            prior_reg       <= '0;
            in_valid_reg    <= 1'b0;
            done_reg        <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                device_type_reg <= cfg_wdata;
            end
            if (run_end && ctrl.accepted && (in_reg.func == FUNC_POINTER)) begin
                prior_reg <= in_reg.button_bits;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            done_reg <= done_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg.func        <= s_tuser[0];
            in_reg.key_down    <= s_tdata[0];
            in_reg.key_id      <= s_tdata[16:1];
            in_reg.delta_x     <= s_tdata[48:17];
            in_reg.delta_y     <= s_tdata[80:49];
            in_reg.wheel_delta <= s_tdata[112:81];
            in_reg.button_bits <= s_tdata[115:113];
        end
        if (load) begin
            m_reg <= rec;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_reg.event_value, m_reg.event_code};
    assign m_tuser  = {m_reg.rejected, m_reg.event_type};
    assign m_tlast  = m_reg.last;

    `IERG_ASSERT_SAME(a_free_only_at_run_end, in_valid_reg && s_tready, run_end, "report released before its last record")
    `IERG_ASSERT_SAME(a_done_within_present, in_valid_reg, (done_reg & ~ctrl.present) == '0, "sent slot not part of the run")
    `IERG_ASSERT_SAME(a_reject_is_last, m_valid_reg && m_reg.rejected, m_reg.last, "rejected record not last")
    `IERG_ASSERT_NEXT(a_buttons_hold_mid_run, !run_end, $stable(prior_reg), "button state changed mid-run")

endmodule

>>> bench/input_event_record_generator_core_tb.sv
module input_event_record_generator_core_tb;
    import ierg_pkg::*;

    // device code with no meaning; every report is rejected
    localparam logic [1:0] DEV_UNDEFINED = 2'd3;
    localparam int MAX_SHOWN = 10;

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic [1:0]   cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [119:0] s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [47:0]  m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;

    input_event_record_generator_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // predictor state
    logic [1:0] device_model;
    logic [2:0] prior_buttons_model;
    rec_t       expected_records [$];

    int  mismatches;
    int  reports_sent;
    int  records_checked;
    int  rejections_seen;
    bit  tx_idle_on;
    bit  rx_idle_on;
    bit  hold_go;
    int  hold_len;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic rec_t make_record(logic [1:0] kind, logic [15:0] code,
                                         logic [31:0] value, logic rej);
        rec_t r;
        r.event_type  = kind;
        r.event_code  = code;
        r.event_value = value;
        r.rejected    = rej;
        r.last        = 1'b0;
        return r;
    endfunction

    // Works out the record run for one report and queues it.
    function automatic void predict_event_run(report_t r);
        rec_t       recs [NUM_SLOTS];
        int         n;
        logic [1:0] axis_kind;
        logic       now_b;
        n = 0;
        if (r.func == FUNC_KEY && device_model == DEV_KEYBOARD) begin
            recs[n++] = make_record(EVT_KEY, r.key_id, {31'b0, r.key_down}, 1'b0);
            recs[n++] = make_record(EVT_SYNC, 16'h0, 32'h0, 1'b0);
        end else if (r.func == FUNC_POINTER &&
                     (device_model == DEV_MOUSE || device_model == DEV_TABLET)) begin
            axis_kind = (device_model == DEV_MOUSE) ? EVT_REL : EVT_ABS;
            recs[n++] = make_record(axis_kind, AXIS_X, r.delta_x, 1'b0);
            recs[n++] = make_record(axis_kind, AXIS_Y, r.delta_y, 1'b0);
            // wheel stays relative even on a tablet
            if (r.wheel_delta != 32'h0)
                recs[n++] = make_record(EVT_REL, AXIS_WHEEL, r.wheel_delta, 1'b0);
            for (int i = 0; i < NUM_BTNS; i++) begin
                now_b = r.button_bits[i];
                if (now_b != prior_buttons_model[i])
                    recs[n++] = make_record(EVT_KEY, BTN_CODES[i], {31'b0, now_b}, 1'b0);
            end
            prior_buttons_model = r.button_bits;
            recs[n++] = make_record(EVT_SYNC, 16'h0, 32'h0, 1'b0);
        end else begin
            recs[n++] = make_record(EVT_SYNC, 16'h0, 32'h0, 1'b1);
        end
        recs[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            expected_records.push_back(recs[i]);
    endfunction

    task automatic note_mismatch(input string what, input rec_t want, input rec_t got);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("mismatch (%s) at %0t: exp type %0d code %h value %h rej %b last %b",
                     what, $time, want.event_type, want.event_code, want.event_value,
                     want.rejected, want.last,
                     "\n    got type %0d code %h value %h rej %b last %b",
                     got.event_type, got.event_code, got.event_value, got.rejected, got.last);
    endtask

    // result checker
    always @(posedge aclk) begin : record_check
        rec_t got;
        rec_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.event_type  = m_tuser[1:0];
            got.event_code  = m_tdata[15:0];
            got.event_value = m_tdata[47:16];
            got.rejected    = m_tuser[2];
            got.last        = m_tlast;
            records_checked++;
            if (got.rejected)
                rejections_seen++;
            if (expected_records.size() == 0) begin
                note_mismatch("no record due", got, got);
            end else begin
                want = expected_records.pop_front();
                if (got !== want)
                    note_mismatch("field", want, got);
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin : receiver
        int hold_left;
        bit hold_seen;
        m_tready = 1'b0;
        hold_left = 0;
        hold_seen = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_go != hold_seen) begin
                hold_seen = hold_go;
                hold_left = hold_len;
            end
            if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else begin
                m_tready = !(rx_idle_on && $urandom_range(0, 99) < 7);
            end
        end
    end

    initial begin
        #(12 * 300000);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Entered and left at a falling edge; s_tvalid stays high after a transfer.
    task automatic send_report(input report_t r);
        logic [127:0] noise;
        while (tx_idle_on && $urandom_range(0, 99) < 7) begin
            noise = {$urandom, $urandom, $urandom, $urandom};
            s_tvalid = 1'b0;
            s_tdata = noise[119:0];
            s_tuser = noise[120];
            @(negedge aclk);
        end
        s_tdata  = {4'b0, r.button_bits, r.wheel_delta, r.delta_y, r.delta_x,
                    r.key_id, r.key_down};
        s_tuser  = r.func;
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predict_event_run(r);
        reports_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (expected_records.size() != 0)
            @(negedge aclk);
    endtask

    task automatic set_device(input logic [1:0] dev);
        wait_drained();
        repeat (2) @(negedge aclk);
        cfg_wdata = dev;
        cfg_we = 1'b1;
        @(negedge aclk);
        cfg_we = 1'b0;
        device_model = dev;
    endtask

    function automatic logic [31:0] pick_word();
        unique case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3: return 32'($urandom_range(0, 40)) - 32'd20;
            default: return $urandom;
        endcase
    endfunction

    // unused fields are filled at random; the block must ignore them
    function automatic report_t make_key(logic down, logic [15:0] code);
        report_t r;
        r.func        = FUNC_KEY;
        r.key_down    = down;
        r.key_id      = code;
        r.delta_x     = $urandom;
        r.delta_y     = $urandom;
        r.wheel_delta = $urandom;
        r.button_bits = 3'($urandom_range(0, 7));
        return r;
    endfunction

    function automatic report_t make_pointer(logic [31:0] dx, logic [31:0] dy,
                                             logic [31:0] wheel, logic [2:0] btn);
        report_t r;
        r.func        = FUNC_POINTER;
        r.key_down    = 1'($urandom_range(0, 1));
        r.key_id      = 16'($urandom_range(0, 65535));
        r.delta_x     = dx;
        r.delta_y     = dy;
        r.wheel_delta = wheel;
        r.button_bits = btn;
        return r;
    endfunction

    function automatic report_t random_report(logic [1:0] dev);
        logic       well_formed;
        logic [31:0] wheel;
        report_t    r;
        well_formed = ($urandom_range(0, 99) < 88);
        wheel = ($urandom_range(0, 99) < 40) ? 32'h0 : pick_word();
        r = make_pointer(pick_word(), pick_word(), wheel, 3'($urandom_range(0, 7)));
        if ((dev == DEV_KEYBOARD) == well_formed || dev == DEV_UNDEFINED && $urandom_range(0, 1))
            r = make_key(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
        return r;
    endfunction

    task automatic test_keyboard_directed();
        set_device(DEV_KEYBOARD);
        send_report(make_key(1'b1, 16'h0000));
        send_report(make_key(1'b0, 16'hFFFF));
        send_report(make_key(1'b1, 16'h1234));
        send_report(make_pointer(32'h1, 32'h2, 32'h3, 3'd7));
    endtask

    task automatic test_mouse_directed();
        set_device(DEV_MOUSE);
        send_report(make_pointer(32'h0, 32'h0, 32'h0, 3'd0));
        send_report(make_pointer(32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 3'd7));
        send_report(make_pointer(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 3'd7));
        send_report(make_pointer(32'hFFFF_FFFF, 32'h1, 32'h7FFF_FFFF, 3'd2));
        send_report(make_pointer(32'h5, 32'hFFFF_FFFB, 32'h0, 3'd5));
        send_report(make_key(1'b1, 16'h001E));
    endtask

    task automatic test_tablet_directed();
        set_device(DEV_TABLET);
        send_report(make_pointer(32'h0, 32'h0, 32'hFFFF_FFFF, 3'd5));
        send_report(make_pointer(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 3'd0));
        send_report(make_key(1'b0, 16'hFFFF));
    endtask

    // undefined device rejects all; button memory must survive the rejections
    task automatic test_undefined_device();
        set_device(DEV_UNDEFINED);
        send_report(make_key(1'b1, 16'h0042));
        send_report(make_pointer(32'h10, 32'h20, 32'h30, 3'd7));
        set_device(DEV_MOUSE);
        send_report(make_pointer(32'h1, 32'h1, 32'h0, 3'd0));
    endtask

    task automatic test_random_phases();
        logic [1:0] order [10];
        order = '{DEV_MOUSE, DEV_KEYBOARD, DEV_TABLET, DEV_UNDEFINED, DEV_MOUSE,
                  DEV_TABLET, DEV_KEYBOARD, DEV_MOUSE, DEV_TABLET, DEV_KEYBOARD};
        for (int p = 0; p < 10; p++) begin
            set_device(order[p]);
            // one phase runs flat out on both sides
            tx_idle_on = (p != 4);
            rx_idle_on = (p != 4);
            for (int k = 0; k < 30; k++)
                send_report(random_report(order[p]));
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // receiver holds off while reports keep coming, so the input stalls
    task automatic test_backpressure();
        set_device(DEV_MOUSE);
        hold_len = 60;
        hold_go = !hold_go;
        for (int k = 0; k < 14; k++)
            send_report(make_pointer(pick_word(), pick_word(), pick_word(),
                                     3'($urandom_range(0, 7))));
        wait_drained();
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 2'd0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        device_model = DEV_KEYBOARD;
        prior_buttons_model = 3'b000;
        mismatches = 0;
        reports_sent = 0;
        records_checked = 0;
        rejections_seen = 0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        hold_go = 1'b0;
        hold_len = 0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_keyboard_directed();
        test_mouse_directed();
        test_tablet_directed();
        test_undefined_device();
        test_random_phases();
        test_backpressure();

        wait_drained();
        repeat (10) @(posedge aclk);
        if (expected_records.size() != 0) begin
            mismatches++;
            $display("%0d expected records never arrived", expected_records.size());
        end
        $display("Sent %0d key/pointer reports over keyboard, mouse, tablet and undefined",
                 reports_sent);
        $display("device types; checked %0d event records, %0d of them rejections.",
                 records_checked, rejections_seen);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> input_event_record_generator_core.f
+incdir+hdl
hdl/ierg_pkg.sv
hdl/ierg_rec_gen.sv
hdl/input_event_record_generator_core.sv
bench/input_event_record_generator_core_tb.sv
